[src/fcht_pkg.sv]
// Package: shared constants and types for the flow counter hash table.
package fcht_pkg;

  localparam int unsigned TableSlots = 1024;
  localparam int unsigned FillW = 11;
  localparam logic [FillW-1:0] FillLimitReset = 11'd716;
  localparam logic [63:0] FnvBasis = 64'd1469598103934665603;
  localparam logic [63:0] FnvPrime = 64'd1099511628211;
  localparam int unsigned KeyBytes = 48;
  localparam int unsigned KeyW = KeyBytes * 8;
  localparam int unsigned CntW = 32;
  localparam int unsigned BytesW = 48;
  // Key, counters and a used bit at the top
  localparam int unsigned EntryW = KeyW + CntW + BytesW + 1;

  localparam logic [1:0] StEmpty = 2'd0;
  localparam logic [1:0] StHit = 2'd1;
  localparam logic [1:0] StNew = 2'd2;
  localparam logic [1:0] StFull = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_MUL, S_RDREQ, S_RDWAIT, S_CHECK, S_WRITE, S_OUT
  } state_e;

  // Hash unit control and status.
  typedef struct packed {
    logic start;
  } hash_ctl_t;

  typedef struct packed {
    logic        done;
    logic [63:0] hash;
  } hash_sts_t;

endpackage

[src/fcht_ram.sv]
// Generic single-port RAM with registered read.
module fcht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[src/fcht_hash.sv]
// Iterative FNV-1a-style 64-bit hash over the 48-byte key, one byte at a time (non-standard offset basis).
module fcht_hash (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  fcht_pkg::hash_ctl_t     ctl_i,
  input  logic [fcht_pkg::KeyW-1:0] key_i,
  output fcht_pkg::hash_sts_t     sts_o
);

  logic [63:0] h_q, h_d;
  logic [63:0] x_q, x_d;
  logic [5:0]  idx_q, idx_d;
  logic        busy_q, busy_d;
  logic        phase_q, phase_d;
  logic        done_q, done_d;
  logic [fcht_pkg::KeyW-1:0] key_q, key_d;

  // Xor one byte, then multiply by the prime in the next cycle
  always_comb begin
    h_d = h_q;
    x_d = x_q;
    idx_d = idx_q;
    busy_d = busy_q;
    phase_d = phase_q;
    done_d = 1'b0;
    key_d = key_q;
    if (ctl_i.start) begin
      h_d = fcht_pkg::FnvBasis;
      idx_d = '0;
      busy_d = 1'b1;
      phase_d = 1'b0;
      key_d = key_i;
    end else if (busy_q) begin
      if (!phase_q) begin
        x_d = h_q ^ {56'd0, key_q[7:0]};
        key_d = key_q >> 8;
        phase_d = 1'b1;
      end else begin
        // Prime is 2^40 + 0x1B3: multiply with shifts and adds
        h_d = (x_q << 40) + (x_q << 8) + (x_q << 7) + (x_q << 5) + (x_q << 4) +
              (x_q << 1) + x_q;
        phase_d = 1'b0;
        idx_d = idx_q + 6'd1;
        if (idx_q == 6'(fcht_pkg::KeyBytes - 1)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      busy_q <= 1'b0;
      phase_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      busy_q <= busy_d;
      phase_q <= phase_d;
      done_q <= done_d;
    end
  end

  // Advance datapath
  always_ff @(posedge clk_i) begin
    h_q <= h_d;
    x_q <= x_d;
    key_q <= key_d;
  end

  assign sts_o.done = done_q;
  assign sts_o.hash = h_q;

endmodule

[src/flow_counter_hash_table_unit.sv]
// Top level: flow counter hash table with FNV-1a-style indexing and linear probing.
// A read passes RDREQ, RDWAIT, CHECK and OUT; a record first hashes the key byte by byte
// (HASH, MUL), probes slot by slot through RDREQ, RDWAIT and CHECK, and passes WRITE when
// the slot is written, then OUT. Throughput: one transaction at a time; s_axis_tready is
// low until the result has been taken. Reset: fill count zero, limit 716, then a clearing
// pass over all TableSlots slots (1024 by default) with s_axis_tready low.
module flow_counter_hash_table_unit #(
  parameter int unsigned TableSlots = fcht_pkg::TableSlots
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: slot_index[9:0], pid, is_udp, is_ipv6, dst_port, src_addr_hi,
  //        src_addr_lo, dst_addr_hi, dst_addr_lo, exe_tag, byte_count (pad to 416)
  input  logic [415:0] s_axis_tdata,
  // tuser: mode
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: status, flow_pid, flow_udp, flow_ipv6, flow_port, flow_src_hi,
  //        flow_src_lo, flow_dst_hi, flow_dst_lo, flow_exe, event_total,
  //        byte_total (pad to 456)
  output logic [455:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [10:0]  cfg_data_i
);

  localparam int unsigned AW = $clog2(TableSlots);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned KW = fcht_pkg::KeyW;
  localparam int unsigned EW = fcht_pkg::EntryW;

  fcht_pkg::state_e state_q, state_d;
  logic [10:0]  limit_q;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] probes_q, probes_d;
  logic [AW-1:0] slot_q, slot_d;
  logic [KW-1:0] key_q, key_d;
  logic [31:0]  add_q, add_d;
  logic         mode_q, mode_d;
  logic [455:0] out_q, out_d;
  logic         ram_we;
  logic [EW-1:0] ram_wdata, ram_rdata, ent_q, ent_d;
  logic         used;
  fcht_pkg::hash_ctl_t hctl;
  fcht_pkg::hash_sts_t hsts;

  // Key in hash layout: pid, kind, zero, port, src hi/lo, dst hi/lo, exe
  logic [KW-1:0] in_key;
  assign in_key = {s_axis_tdata[379:316], s_axis_tdata[315:252], s_axis_tdata[251:188],
                   s_axis_tdata[187:124], s_axis_tdata[123:60], s_axis_tdata[59:44],
                   8'd0, 6'd0, s_axis_tdata[43], s_axis_tdata[42], s_axis_tdata[41:10]};

  fcht_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (hctl),
    .key_i  (key_q),
    .sts_o  (hsts)
  );

  fcht_ram #(.Width(EW), .Depth(TableSlots)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (slot_q),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  logic [31:0] ev;
  logic [47:0] by;
  logic [48:0] bsum;
  logic        match;
  assign used = ent_q[EW-1];
  assign ev = ent_q[KW +: 32];
  assign by = ent_q[KW+32 +: 48];
  assign bsum = {1'b0, by} + {17'd0, add_q};
  assign match = (ent_q[KW-1:0] == key_q);

  // Pack a result from status, key and counters
  function automatic logic [455:0] pack(logic [1:0] st, logic [KW-1:0] k,
                                        logic [31:0] e, logic [47:0] b);
    pack = {4'd0, b, e, k[383:64], k[63:48], k[33], k[32], k[31:0], st};
  endfunction

  // Sequence clearing, hash, probe, update and output
  always_comb begin
    state_d = state_q;
    fill_d = fill_q;
    probes_d = probes_q;
    slot_d = slot_q;
    key_d = key_q;
    add_d = add_q;
    mode_d = mode_q;
    out_d = out_q;
    ent_d = ent_q;
    ram_we = 1'b0;
    ram_wdata = {1'b1, 48'(add_q), 32'd1, key_q};
    hctl.start = 1'b0;
    case (state_q)
      fcht_pkg::S_CLEAR: begin
        ram_we = 1'b1;
        ram_wdata = '0;
        slot_d = slot_q + AW'(1);
        if (slot_q == AW'(TableSlots - 1)) begin
          state_d = fcht_pkg::S_IDLE;
        end
      end
      fcht_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          key_d = in_key;
          add_d = s_axis_tdata[411:380];
          mode_d = s_axis_tuser;
          slot_d = AW'(s_axis_tdata[9:0]);
          probes_d = '0;
          state_d = s_axis_tuser ? fcht_pkg::S_RDREQ : fcht_pkg::S_HASH;
        end
      end
      fcht_pkg::S_HASH: begin
        hctl.start = 1'b1;
        state_d = fcht_pkg::S_MUL;
      end
      fcht_pkg::S_MUL: begin
        if (hsts.done) begin
          slot_d = hsts.hash[AW-1:0];
          state_d = fcht_pkg::S_RDREQ;
        end
      end
      fcht_pkg::S_RDREQ: begin
        state_d = fcht_pkg::S_RDWAIT;
      end
      fcht_pkg::S_RDWAIT: begin
        ent_d = ram_rdata;
        state_d = fcht_pkg::S_CHECK;
      end
      fcht_pkg::S_CHECK: begin
        state_d = fcht_pkg::S_OUT;
        if (mode_q) begin
          out_d = used ? pack(fcht_pkg::StHit, ent_q[KW-1:0], ev, by) : '0;
        end else if (!used) begin
          if (32'(fill_q) >= 32'(limit_q)) begin
            out_d = pack(fcht_pkg::StFull, key_q, '0, '0);
          end else begin
            out_d = pack(fcht_pkg::StNew, key_q, 32'd1, 48'(add_q));
            state_d = fcht_pkg::S_WRITE;
          end
        end else if (match) begin
          ent_d[KW +: 32] = (ev == '1) ? ev : ev + 32'd1;
          ent_d[KW+32 +: 48] = bsum[48] ? '1 : bsum[47:0];
          out_d = pack(fcht_pkg::StHit, key_q, ent_d[KW +: 32], ent_d[KW+32 +: 48]);
          state_d = fcht_pkg::S_WRITE;
        end else if (probes_q == CW'(TableSlots - 1)) begin
          out_d = pack(fcht_pkg::StFull, key_q, '0, '0);
        end else begin
          probes_d = probes_q + CW'(1);
          slot_d = slot_q + AW'(1);
          state_d = fcht_pkg::S_RDREQ;
        end
      end
      fcht_pkg::S_WRITE: begin
        ram_we = 1'b1;
        if (used) begin
          ram_wdata = ent_q;
        end else begin
          fill_d = fill_q + CW'(1);
        end
        state_d = fcht_pkg::S_OUT;
      end
      fcht_pkg::S_OUT: begin
        if (m_axis_tready) begin
          state_d = fcht_pkg::S_IDLE;
        end
      end
      default: state_d = fcht_pkg::S_IDLE;
    endcase
  end

  // Hold state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcht_pkg::S_CLEAR;
      limit_q <= fcht_pkg::FillLimitReset;
      fill_q <= '0;
      slot_q <= '0;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;
      slot_q <= slot_d;
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // Advance payload registers
  always_ff @(posedge clk_i) begin
    probes_q <= probes_d;
    key_q <= key_d;
    add_q <= add_d;
    mode_q <= mode_d;
    out_q <= out_d;
    ent_q <= ent_d;
  end

  assign s_axis_tready = (state_q == fcht_pkg::S_IDLE);
  assign m_axis_tvalid = (state_q == fcht_pkg::S_OUT);
  assign m_axis_tdata = out_q;
  assign cfg_ready_o = 1'b1;

endmodule
